FILE: rtl/tlfd_pkg.sv
// Shared types and constants for the typed length frame deframer.
package tlfd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned PaddrW   = 5;
  localparam int unsigned PdataW   = 32;

  localparam logic [ByteW-1:0] EventTypeRst  = 8'd1;
  localparam logic [ByteW-1:0] MsgTypeRst    = 8'd2;
  localparam logic [ByteW-1:0] EndMarkerRst  = 8'd85;
  localparam logic [ByteW-1:0] OverheadRst   = 8'd4;
  localparam logic [LenW-1:0]  MaxTotalRst   = 16'd64;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_EVENT_TYPE = 3'd0,
    REG_MSG_TYPE   = 3'd1,
    REG_END_MARKER = 3'd2,
    REG_OVERHEAD   = 3'd3,
    REG_MAX_TOTAL  = 3'd4
  } tlfd_reg_e;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_END     = 3'd4
  } tlfd_phase_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_DROP = 2'd2
  } tlfd_kind_e;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_TYPE   = 2'd1,
    CAUSE_LENGTH = 2'd2,
    CAUSE_END    = 2'd3
  } tlfd_cause_e;

  typedef struct packed {
    logic [ByteW-1:0] event_type_code;
    logic [ByteW-1:0] message_type_code;
    logic [ByteW-1:0] end_marker_code;
    logic [ByteW-1:0] overhead_bytes;
    logic [LenW-1:0]  max_total_length;
  } tlfd_cfg_t;

  typedef struct packed {
    tlfd_kind_e       kind;
    logic             channel;
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0]  payload_length;
    tlfd_cause_e      drop_cause;
  } tlfd_result_t;

endpackage

FILE: rtl/tlfd_core.sv
// Frame phase machine: one received byte per accepted transaction, zero or one result.
module tlfd_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            acc_i,
  input  logic [tlfd_pkg::ByteW-1:0]      rx_byte_i,
  input  tlfd_pkg::tlfd_cfg_t             cfg_i,
  output logic                            res_valid_o,
  output tlfd_pkg::tlfd_result_t          res_o
);
  import tlfd_pkg::*;

  tlfd_phase_e      phase_q, phase_d;
  logic             chan_q, chan_d;
  logic [ByteW-1:0] len_hi_q, len_hi_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [LenW-1:0]  plen_q, plen_d;

  logic [LenW-1:0]  total;
  logic [LenW-1:0]  overhead_ext;
  logic [LenW-1:0]  total_net;
  logic             len_bad;

  assign total        = {len_hi_q, rx_byte_i};
  assign overhead_ext = {{(LenW-ByteW){1'b0}}, cfg_i.overhead_bytes};
  assign total_net    = total - overhead_ext;
  assign len_bad      = (total > cfg_i.max_total_length) || (total < overhead_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      chan_q   <= 1'b0;
      len_hi_q <= '0;
      left_q   <= '0;
      plen_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      chan_q   <= chan_d;
      len_hi_q <= len_hi_d;
      left_q   <= left_d;
      plen_q   <= plen_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    chan_d      = chan_q;
    len_hi_d    = len_hi_q;
    left_d      = left_q;
    plen_d      = plen_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_DATA, channel: chan_q, data_byte: '0,
                    payload_length: '0, drop_cause: CAUSE_NONE};
    if (acc_i) begin
      case (phase_q)
        PH_LEN_HI: begin
          len_hi_d = rx_byte_i;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len_bad) begin
            phase_d          = PH_HUNT;
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_DROP;
            res_o.drop_cause = CAUSE_LENGTH;
          end else begin
            plen_d  = total_net;
            left_d  = total_net;
            phase_d = (total_net == '0) ? PH_END : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          left_d          = left_q - 1'b1;
          phase_d         = (left_q == {{(LenW-1){1'b0}}, 1'b1}) ? PH_END : PH_PAYLOAD;
          res_valid_o     = 1'b1;
          res_o.data_byte = rx_byte_i;
        end
        PH_END: begin
          phase_d     = PH_HUNT;
          res_valid_o = 1'b1;
          if (rx_byte_i == cfg_i.end_marker_code) begin
            res_o.kind           = KIND_DONE;
            res_o.payload_length = plen_q;
          end else begin
            res_o.kind       = KIND_DROP;
            res_o.drop_cause = CAUSE_END;
          end
        end
        default: begin
          // Event code wins when both codes match.
          if (rx_byte_i == cfg_i.event_type_code) begin
            chan_d  = 1'b0;
            phase_d = PH_LEN_HI;
          end else if (rx_byte_i == cfg_i.message_type_code) begin
            chan_d  = 1'b1;
            phase_d = PH_LEN_HI;
          end else begin
            phase_d          = PH_HUNT;
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_DROP;
            res_o.channel    = 1'b0;
            res_o.drop_cause = CAUSE_TYPE;
          end
        end
      endcase
    end
  end

  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> left_q != '0)
    else $error("payload phase with no bytes left");

  a_len_hi_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && phase_q == PH_LEN_HI |=> phase_q == PH_LEN_LO)
    else $error("high length byte did not advance to low length byte");

  a_len_hi_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && phase_q == PH_LEN_HI |-> !res_valid_o)
    else $error("result produced on high length byte");

endmodule

FILE: rtl/typed_length_frame_deframer.sv
// Top level: register port, phase machine and output register with skid stage.
//
//   port group   dir  handshake             payload
//   rx input     in   in_valid_i/in_ready_o rx_byte_i
//   result       out  out_valid_o/out_ready_i result_kind_o, channel_o, data_byte_o,
//                                            payload_length_o, drop_cause_o
//   registers    in   APB psel/penable      paddr, pwdata, prdata
//
// One byte per cycle while in_ready_o is high. A single phase-machine pass feeds
// the output register, or the skid stage while the output register is stalled.
// in_ready_o drops only while the skid stage holds a result, i.e. after a stalled cycle.
// Reset puts the machine in hunt with registers at their defaults; no clearing pass.
module typed_length_frame_deframer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [tlfd_pkg::ByteW-1:0]         rx_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         result_kind_o,
  output logic                               channel_o,
  output logic [tlfd_pkg::ByteW-1:0]         data_byte_o,
  output logic [tlfd_pkg::LenW-1:0]          payload_length_o,
  output logic [1:0]                         drop_cause_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tlfd_pkg::PaddrW-1:0]        paddr,
  input  logic [tlfd_pkg::PdataW-1:0]        pwdata,
  output logic [tlfd_pkg::PdataW-1:0]        prdata,
  output logic                               pready
);
  import tlfd_pkg::*;

  tlfd_cfg_t    cfg_q;
  tlfd_reg_e    reg_sel;
  logic         cfg_we;

  logic         acc;
  logic         res_valid;
  tlfd_result_t res;

  logic         out_valid_q, skid_valid_q;
  tlfd_result_t out_q, skid_q;
  logic         out_pop;

  // Register port
  assign pready  = 1'b1;
  assign reg_sel = tlfd_reg_e'(paddr[PaddrW-1:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.event_type_code   <= EventTypeRst;
      cfg_q.message_type_code <= MsgTypeRst;
      cfg_q.end_marker_code   <= EndMarkerRst;
      cfg_q.overhead_bytes    <= OverheadRst;
      cfg_q.max_total_length  <= MaxTotalRst;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_EVENT_TYPE: cfg_q.event_type_code   <= pwdata[ByteW-1:0];
        REG_MSG_TYPE:   cfg_q.message_type_code <= pwdata[ByteW-1:0];
        REG_END_MARKER: cfg_q.end_marker_code   <= pwdata[ByteW-1:0];
        REG_OVERHEAD:   cfg_q.overhead_bytes    <= pwdata[ByteW-1:0];
        REG_MAX_TOTAL:  cfg_q.max_total_length  <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_EVENT_TYPE: prdata = {{(PdataW-ByteW){1'b0}}, cfg_q.event_type_code};
      REG_MSG_TYPE:   prdata = {{(PdataW-ByteW){1'b0}}, cfg_q.message_type_code};
      REG_END_MARKER: prdata = {{(PdataW-ByteW){1'b0}}, cfg_q.end_marker_code};
      REG_OVERHEAD:   prdata = {{(PdataW-ByteW){1'b0}}, cfg_q.overhead_bytes};
      REG_MAX_TOTAL:  prdata = {{(PdataW-LenW){1'b0}}, cfg_q.max_total_length};
      default:        prdata = '0;
    endcase
  end

  // Datapath
  assign in_ready_o = !skid_valid_q;
  assign acc        = in_valid_i && in_ready_o;

  tlfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register plus skid stage
  assign out_pop = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      // New results arrive only while the skid stage is empty.
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end else if (res_valid && out_valid_q) begin
        skid_valid_q <= 1'b1;
      end
      if (res_valid || (out_pop && skid_valid_q)) begin
        out_valid_q <= 1'b1;
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if (res_valid && (!out_valid_q || out_pop)) begin
      out_q <= res;
    end
    if (res_valid && out_valid_q && !out_pop) begin
      skid_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_q.kind;
  assign channel_o        = out_q.channel;
  assign data_byte_o      = out_q.data_byte;
  assign payload_length_o = out_q.payload_length;
  assign drop_cause_o     = out_q.drop_cause;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");

  a_data_only_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind != KIND_DATA |-> out_q.data_byte == '0)
    else $error("data byte set on a non-payload result");

  a_len_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind != KIND_DONE |-> out_q.payload_length == '0)
    else $error("payload length set on a result that is not frame complete");

endmodule
